// ----- src/sts_pkg.sv -----
// Types, token codes and character classes for the statement terminator scanner.
// No dependencies; used by statement_terminator_scanner.
package sts_pkg;

   localparam int CP_BITS  = 21;
   localparam int NUM_KW   = 6;
   localparam int KW_CHARS = 10;

   localparam logic [CP_BITS-1:0] WIDE_MIN = 21'h7F;

   // token kinds
   localparam logic [1:0] TK_NONE = 2'd0;
   localparam logic [1:0] TK_TERM = 2'd1;
   localparam logic [1:0] TK_DOT  = 2'd2;

   // keyword candidate masks: bit 0 as, 1 in, 2 instanceof, 3 else, 4 catch, 5 finally
   localparam logic [NUM_KW-1:0] KW_ALL  = 6'h3F;
   localparam logic [NUM_KW-1:0] KW_BANG = 6'h06;

   typedef enum logic [16:0] {
      PH_IDLE    = 17'b00000000000000001,
      PH_DOT     = 17'b00000000000000010,
      PH_LEAD    = 17'b00000000000000100,
      PH_RUN     = 17'b00000000000001000,
      PH_F_SLASH = 17'b00000000000010000,
      PH_F_LINE  = 17'b00000000000100000,
      PH_F_BLOCK = 17'b00000000001000000,
      PH_F_TAIL  = 17'b00000000010000000,
      PH_L_SCAN  = 17'b00000000100000000,
      PH_L_SLASH = 17'b00000001000000000,
      PH_L_LINE  = 17'b00000010000000000,
      PH_L_BLOCK = 17'b00000100000000000,
      PH_L_TAIL  = 17'b00001000000000000,
      PH_BANG    = 17'b00010000000000000,
      PH_PLUS    = 17'b00100000000000000,
      PH_MINUS   = 17'b01000000000000000,
      PH_WORD    = 17'b10000000000000000
   } phase_type;

   function automatic logic eq(input logic [CP_BITS-1:0] c, input logic [7:0] ch);
      return c == {13'd0, ch};
   endfunction

   function automatic logic is_start_char(input logic [CP_BITS-1:0] c);
      return (c >= {13'd0, "a"} && c <= {13'd0, "z"}) ||
             (c >= {13'd0, "A"} && c <= {13'd0, "Z"}) ||
             eq(c, "_") || (c > WIDE_MIN);
   endfunction

   function automatic logic is_ident_char(input logic [CP_BITS-1:0] c);
      return is_start_char(c) || (c >= {13'd0, "0"} && c <= {13'd0, "9"});
   endfunction

   function automatic logic is_inline(input logic [CP_BITS-1:0] c);
      return eq(c, " ") || eq(c, 8'h09) || eq(c, 8'h0D) || eq(c, 8'h0C);
   endfunction

   function automatic logic is_newline(input logic [CP_BITS-1:0] c);
      return eq(c, 8'h0A);
   endfunction

   // operators that continue the expression onto the next line
   function automatic logic is_cont_op(input logic [CP_BITS-1:0] c);
      logic hit;
      hit = 1'b0;
      if (c[CP_BITS-1:8] == 13'd0) begin
         case (c[7:0])
            ".", "?", ":", ",", "*", "%", "<", ">", "=", "&", "^", "|",
            ")", "]", "}": hit = 1'b1;
            default: hit = 1'b0;
         endcase
      end
      return hit;
   endfunction

   // keyword text, left justified
   function automatic logic [8*KW_CHARS-1:0] kw_word(input logic [2:0] k);
      logic [8*KW_CHARS-1:0] w;
      case (k)
         3'd0:    w = {"as", 64'd0};
         3'd1:    w = {"in", 64'd0};
         3'd2:    w = "instanceof";
         3'd3:    w = {"else", 48'd0};
         3'd4:    w = {"catch", 40'd0};
         3'd5:    w = {"finally", 24'd0};
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kw_len(input logic [2:0] k);
      logic [3:0] n;
      case (k)
         3'd0:    n = 4'd2;
         3'd1:    n = 4'd2;
         3'd2:    n = 4'd10;
         3'd3:    n = 4'd4;
         3'd4:    n = 4'd5;
         3'd5:    n = 4'd7;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
      logic [8*KW_CHARS-1:0] w;
      w = kw_word(k);
      if (i > 4'd9) return 8'd0;
      return w[8*(9 - int'(i)) +: 8];
   endfunction

endpackage

// ----- src/statement_terminator_scanner.sv -----
// Statement terminator scanner: decides terminator / path dot tokens one code point a cycle while not stalled.
// Depends on sts_pkg (phase type, token codes, character classes, keyword table).
// A result passes from the input register into the output register once the output register is free or being read.
// Throughput: one item per cycle unless rsp_ready stalls; input register and output register run concurrently.
// The scan state advances once per item through a single combinational step.
// Reset (synchronous, active high) empties both registers and returns the scan to idle.
module statement_terminator_scanner #(
   parameter int COUNT_BITS = 16,
   parameter int WORD_LIMIT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_scan_start,
   input  logic [20:0] req_code_point,
   input  logic        req_at_end,
   input  logic        req_want_terminator,
   input  logic        req_want_path_dot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_token_kind,
   output logic [15:0] rsp_skipped_count,
   output logic [15:0] rsp_token_length,
   output logic        rsp_length_saturated
);

   localparam int PW = $clog2(WORD_LIMIT);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [PW-1:0] WPOS_LAST = PW'(WORD_LIMIT - 1);

   // input register
   logic        in_valid_ff;
   logic        in_start_ff;
   logic [20:0] in_cp_ff;
   logic        in_end_ff;
   logic        in_wt_ff;
   logic        in_wp_ff;

   // scan state
   sts_pkg::phase_type phase_ff, phase_in;
   logic                  semi_ff, semi_in;
   logic                  star_ff, star_in;
   logic [5:0]            cand_ff, cand_in;
   logic [PW-1:0]         wpos_ff, wpos_in;
   logic                  bang_ff, bang_in;
   logic [COUNT_BITS-1:0] skip_ff, skip_in;
   logic [COUNT_BITS-1:0] cons_ff, cons_in;
   logic [COUNT_BITS-1:0] mark_ff, mark_in;
   logic                  sat_ff, sat_in;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [15:0] skipped_ff;
   logic [15:0] length_ff;
   logic        satout_ff;

   logic        advance;
   logic [20:0] c;
   logic        emit;
   logic [1:0]  kind;
   logic        go_lead, go_run, go_fline, go_ftail, go_lline, go_ltail, go_lscan, go_word;
   logic        word_bang;
   logic        matched;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign c         = in_end_ff ? 21'd0 : in_cp_ff;

   always_comb begin
      phase_in  = phase_ff;
      semi_in   = semi_ff;
      star_in   = star_ff;
      cand_in   = cand_ff;
      wpos_in   = wpos_ff;
      bang_in   = bang_ff;
      skip_in   = skip_ff;
      cons_in   = cons_ff;
      mark_in   = mark_ff;
      sat_in    = sat_ff;
      emit      = 1'b0;
      kind      = sts_pkg::TK_NONE;
      go_lead   = 1'b0;
      go_run    = 1'b0;
      go_fline  = 1'b0;
      go_ftail  = 1'b0;
      go_lline  = 1'b0;
      go_ltail  = 1'b0;
      go_lscan  = 1'b0;
      go_word   = 1'b0;
      word_bang = 1'b0;
      matched   = 1'b0;

      if (in_start_ff) begin
         phase_in = sts_pkg::PH_IDLE;
         semi_in  = 1'b0;
         star_in  = 1'b0;
         cand_in  = '0;
         wpos_in  = '0;
         bang_in  = 1'b0;
         skip_in  = '0;
         cons_in  = '0;
         mark_in  = '0;
         sat_in   = 1'b0;
         if (in_wp_ff && !in_wt_ff && sts_pkg::eq(c, ".")) begin
            cons_in  = COUNT_BITS'(1);
            mark_in  = COUNT_BITS'(1);
            phase_in = sts_pkg::PH_DOT;
         end else if (!in_wt_ff) begin
            emit = 1'b1;
            kind = sts_pkg::TK_NONE;
         end else begin
            go_lead = 1'b1;
         end
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_DOT) begin
         emit = 1'b1;
         kind = sts_pkg::is_start_char(c) ? sts_pkg::TK_DOT : sts_pkg::TK_NONE;
      end

      if (go_lead || (!in_start_ff && phase_ff == sts_pkg::PH_LEAD)) begin
         phase_in = sts_pkg::PH_LEAD;
         if (sts_pkg::is_inline(c)) begin
            if (skip_in == CNT_MAX) sat_in = 1'b1;
            else skip_in = skip_in + 1'b1;
         end else if (sts_pkg::is_newline(c) || sts_pkg::eq(c, ";")) begin
            go_run = 1'b1;
         end else begin
            emit = 1'b1;
            kind = sts_pkg::TK_NONE;
         end
      end

      if (go_run || (!in_start_ff && phase_ff == sts_pkg::PH_RUN)) begin
         phase_in = sts_pkg::PH_RUN;
         if (sts_pkg::is_newline(c) || sts_pkg::eq(c, ";") || sts_pkg::is_inline(c)) begin
            if (sts_pkg::eq(c, ";")) semi_in = 1'b1;
            if (cons_in == CNT_MAX) sat_in = 1'b1;
            else cons_in = cons_in + 1'b1;
         end else begin
            mark_in = cons_in;
            if (semi_in && sts_pkg::eq(c, "/")) begin
               if (cons_in == CNT_MAX) sat_in = 1'b1;
               else cons_in = cons_in + 1'b1;
               phase_in = sts_pkg::PH_F_SLASH;
            end else if (semi_in) begin
               emit = 1'b1;
               kind = sts_pkg::TK_TERM;
            end else begin
               go_lscan = 1'b1;
            end
         end
      end

      // comment folded in after a semicolon
      if (!in_start_ff && phase_ff == sts_pkg::PH_F_SLASH) begin
         if (sts_pkg::eq(c, "/")) begin
            go_fline = 1'b1;
         end else if (sts_pkg::eq(c, "*")) begin
            if (cons_in == CNT_MAX) sat_in = 1'b1;
            else cons_in = cons_in + 1'b1;
            star_in  = 1'b0;
            phase_in = sts_pkg::PH_F_BLOCK;
         end else begin
            emit = 1'b1;
            kind = sts_pkg::TK_TERM;
         end
      end

      if (go_fline || (!in_start_ff && phase_ff == sts_pkg::PH_F_LINE)) begin
         if (!sts_pkg::is_newline(c) && !in_end_ff) begin
            if (cons_in == CNT_MAX) sat_in = 1'b1;
            else cons_in = cons_in + 1'b1;
            phase_in = sts_pkg::PH_F_LINE;
         end else begin
            go_ftail = 1'b1;
         end
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_F_BLOCK) begin
         if (in_end_ff) begin
            go_ftail = 1'b1;
         end else begin
            if (star_in && sts_pkg::eq(c, "/")) phase_in = sts_pkg::PH_F_TAIL;
            else star_in = sts_pkg::eq(c, "*");
            if (cons_in == CNT_MAX) sat_in = 1'b1;
            else cons_in = cons_in + 1'b1;
         end
      end

      if (go_ftail || (!in_start_ff && phase_ff == sts_pkg::PH_F_TAIL)) begin
         phase_in = sts_pkg::PH_F_TAIL;
         if (sts_pkg::is_newline(c) || sts_pkg::is_inline(c)) begin
            if (cons_in == CNT_MAX) sat_in = 1'b1;
            else cons_in = cons_in + 1'b1;
         end else begin
            mark_in = cons_in;
            emit    = 1'b1;
            kind    = sts_pkg::TK_TERM;
         end
      end

      // lookahead past comments on the next line
      if (!in_start_ff && phase_ff == sts_pkg::PH_L_SLASH) begin
         if (sts_pkg::eq(c, "/")) begin
            go_lline = 1'b1;
         end else if (sts_pkg::eq(c, "*")) begin
            star_in  = 1'b0;
            phase_in = sts_pkg::PH_L_BLOCK;
         end else begin
            emit = 1'b1;
            kind = sts_pkg::TK_NONE;
         end
      end

      if (go_lline || (!in_start_ff && phase_ff == sts_pkg::PH_L_LINE)) begin
         if (!sts_pkg::is_newline(c) && !in_end_ff) phase_in = sts_pkg::PH_L_LINE;
         else go_ltail = 1'b1;
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_L_BLOCK) begin
         if (in_end_ff) begin
            go_ltail = 1'b1;
         end else if (star_in && sts_pkg::eq(c, "/")) begin
            phase_in = sts_pkg::PH_L_TAIL;
         end else begin
            star_in  = sts_pkg::eq(c, "*");
            phase_in = sts_pkg::PH_L_BLOCK;
         end
      end

      if (go_ltail || (!in_start_ff && phase_ff == sts_pkg::PH_L_TAIL)) begin
         if (sts_pkg::is_newline(c) || sts_pkg::is_inline(c)) phase_in = sts_pkg::PH_L_TAIL;
         else go_lscan = 1'b1;
      end

      if (go_lscan || (!in_start_ff && phase_ff == sts_pkg::PH_L_SCAN)) begin
         phase_in = sts_pkg::PH_L_SCAN;
         if (sts_pkg::eq(c, "/")) begin
            phase_in = sts_pkg::PH_L_SLASH;
         end else if (sts_pkg::is_cont_op(c)) begin
            emit = 1'b1;
            kind = sts_pkg::TK_NONE;
         end else if (sts_pkg::eq(c, "!")) begin
            phase_in = sts_pkg::PH_BANG;
         end else if (sts_pkg::eq(c, "+")) begin
            phase_in = sts_pkg::PH_PLUS;
         end else if (sts_pkg::eq(c, "-")) begin
            phase_in = sts_pkg::PH_MINUS;
         end else if (sts_pkg::is_start_char(c)) begin
            go_word = 1'b1;
         end else begin
            emit = 1'b1;
            kind = sts_pkg::TK_TERM;
         end
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_BANG) begin
         if (sts_pkg::eq(c, "=")) begin
            emit = 1'b1;
            kind = sts_pkg::TK_NONE;
         end else if (sts_pkg::eq(c, "i")) begin
            go_word   = 1'b1;
            word_bang = 1'b1;
         end else begin
            emit = 1'b1;
            kind = sts_pkg::TK_TERM;
         end
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_PLUS) begin
         emit = 1'b1;
         kind = sts_pkg::eq(c, "=") ? sts_pkg::TK_NONE : sts_pkg::TK_TERM;
      end

      if (!in_start_ff && phase_ff == sts_pkg::PH_MINUS) begin
         emit = 1'b1;
         kind = (sts_pkg::eq(c, "=") || sts_pkg::eq(c, ">")) ? sts_pkg::TK_NONE
                                                             : sts_pkg::TK_TERM;
      end

      if (go_word) begin
         bang_in = word_bang;
         cand_in = word_bang ? sts_pkg::KW_BANG : sts_pkg::KW_ALL;
         wpos_in = '0;
      end

      if (go_word || (!in_start_ff && phase_ff == sts_pkg::PH_WORD)) begin
         phase_in = sts_pkg::PH_WORD;
         if (sts_pkg::is_ident_char(c)) begin
            // characters past the limit no longer narrow the candidates
            if (wpos_in < WPOS_LAST) begin
               for (int k = 0; k < sts_pkg::NUM_KW; k++) begin
                  if (cand_in[k] &&
                      (wpos_in >= PW'(sts_pkg::kw_len(3'(k))) ||
                       !sts_pkg::eq(c, sts_pkg::kw_char(3'(k), wpos_in[3:0]))))
                     cand_in[k] = 1'b0;
               end
               wpos_in = wpos_in + 1'b1;
            end
         end else begin
            for (int k = 0; k < sts_pkg::NUM_KW; k++) begin
               if (cand_in[k] && wpos_in == PW'(sts_pkg::kw_len(3'(k)))) matched = 1'b1;
            end
            emit = 1'b1;
            kind = matched ? sts_pkg::TK_NONE : sts_pkg::TK_TERM;
         end
      end

      if (emit) phase_in = sts_pkg::PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= sts_pkg::PH_IDLE;
         semi_ff      <= 1'b0;
         star_ff      <= 1'b0;
         cand_ff      <= '0;
         wpos_ff      <= '0;
         bang_ff      <= 1'b0;
         skip_ff      <= '0;
         cons_ff      <= '0;
         mark_ff      <= '0;
         sat_ff       <= 1'b0;
      end else begin
         if (req_valid && req_ready) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;

         if (advance) begin
            rsp_valid_ff <= emit;
            phase_ff     <= phase_in;
            semi_ff      <= semi_in;
            star_ff      <= star_in;
            cand_ff      <= cand_in;
            wpos_ff      <= wpos_in;
            bang_ff      <= bang_in;
            skip_ff      <= skip_in;
            cons_ff      <= cons_in;
            mark_ff      <= mark_in;
            sat_ff       <= sat_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_scan_start;
         in_cp_ff    <= req_code_point;
         in_end_ff   <= req_at_end;
         in_wt_ff    <= req_want_terminator;
         in_wp_ff    <= req_want_path_dot;
      end
      if (advance && emit) begin
         kind_ff <= kind;
         if (kind == sts_pkg::TK_TERM) begin
            skipped_ff <= 16'(skip_in);
            length_ff  <= 16'(mark_in);
            satout_ff  <= sat_in;
         end else begin
            skipped_ff <= 16'd0;
            length_ff  <= (kind == sts_pkg::TK_DOT) ? 16'd1 : 16'd0;
            satout_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_token_kind       = kind_ff;
   assign rsp_skipped_count    = skipped_ff;
   assign rsp_token_length     = length_ff;
   assign rsp_length_saturated = satout_ff;

endmodule
